[src/cia_pkg.sv]
`default_nettype none
package cia_pkg;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_POW = 5'd5, OP_NEG = 5'd6, OP_BITNOT = 5'd7, OP_AND = 5'd8, OP_OR = 5'd9,
    OP_XOR = 5'd10, OP_SHL = 5'd11, OP_SHR = 5'd12, OP_USHR = 5'd13, OP_NOT = 5'd14,
    OP_LAND = 5'd15, OP_LOR = 5'd16, OP_WIDEN = 5'd17, OP_EQ = 5'd18, OP_NE = 5'd19,
    OP_LT = 5'd20, OP_LE = 5'd21, OP_GT = 5'd22, OP_GE = 5'd23
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_DIV, ST_DIV_FIX, ST_POW_MUL, ST_POW_CHK,
    ST_POW_SQ, ST_POW_SQCHK, ST_CVT_A, ST_CVT_B, ST_CMP, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic div_step;
    logic div_fix;
    logic pow_mul;
    logic pow_mul_chk;
    logic pow_sq;
    logic pow_sq_chk;
    logic cvt_a;
    logic cvt_b;
    logic cmp;
  } cmd_t;

  typedef struct packed {
    logic fast;
    logic is_div;
    logic is_pow;
    logic is_cvt;
    logic is_cmp;
    logic div_last;
    logic pow_more;
    logic pow_err;
  } status_t;

endpackage
`default_nettype wire

[src/cia_if.sv]
`default_nettype none
interface cia_in_if;
  logic valid;
  logic ready;
  logic [4:0] op;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

interface cia_out_if;
  logic valid;
  logic ready;
  logic signed [63:0] value;
  logic raises;
  modport source (output valid, value, raises, input ready);
  modport sink (input valid, value, raises, output ready);
endinterface
`default_nettype wire

[src/cia_ctrl.sv]
`default_nettype none
module cia_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire cia_pkg::status_t sts,
  output cia_pkg::cmd_t        cmd
);

  cia_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= cia_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cia_pkg::ST_IDLE: if (in_valid) state_next = cia_pkg::ST_DECODE;
      cia_pkg::ST_DECODE: begin
        if (sts.fast) state_next = cia_pkg::ST_DONE;
        else if (sts.is_div) state_next = cia_pkg::ST_DIV;
        else if (sts.is_pow) state_next = cia_pkg::ST_POW_MUL;
        else state_next = cia_pkg::ST_CVT_A;
      end
      cia_pkg::ST_DIV: if (sts.div_last) state_next = cia_pkg::ST_DIV_FIX;
      cia_pkg::ST_DIV_FIX: state_next = cia_pkg::ST_DONE;
      cia_pkg::ST_POW_MUL: state_next = cia_pkg::ST_POW_CHK;
      cia_pkg::ST_POW_CHK: begin
        if (sts.pow_err || !sts.pow_more) state_next = cia_pkg::ST_DONE;
        else state_next = cia_pkg::ST_POW_SQ;
      end
      cia_pkg::ST_POW_SQ: state_next = cia_pkg::ST_POW_SQCHK;
      cia_pkg::ST_POW_SQCHK: begin
        if (sts.pow_err) state_next = cia_pkg::ST_DONE;
        else state_next = cia_pkg::ST_POW_MUL;
      end
      cia_pkg::ST_CVT_A: state_next = cia_pkg::ST_CVT_B;
      cia_pkg::ST_CVT_B:
        state_next = sts.is_cmp ? cia_pkg::ST_CMP : cia_pkg::ST_DONE;
      cia_pkg::ST_CMP: state_next = cia_pkg::ST_DONE;
      cia_pkg::ST_DONE: if (out_ready) state_next = cia_pkg::ST_IDLE;
      default: state_next = cia_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      cia_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cia_pkg::ST_DECODE: cmd.decode = 1'b1;
      cia_pkg::ST_DIV: cmd.div_step = 1'b1;
      cia_pkg::ST_DIV_FIX: cmd.div_fix = 1'b1;
      cia_pkg::ST_POW_MUL: cmd.pow_mul = 1'b1;
      cia_pkg::ST_POW_CHK: cmd.pow_mul_chk = 1'b1;
      cia_pkg::ST_POW_SQ: cmd.pow_sq = 1'b1;
      cia_pkg::ST_POW_SQCHK: cmd.pow_sq_chk = 1'b1;
      cia_pkg::ST_CVT_A: cmd.cvt_a = 1'b1;
      cia_pkg::ST_CVT_B: cmd.cvt_b = 1'b1;
      cia_pkg::ST_CMP: cmd.cmp = 1'b1;
      cia_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/cia_dp.sv]
`default_nettype none
module cia_dp (
  input  wire logic                clk,
  input  wire logic [4:0]          op_in,
  input  wire logic [63:0]         a_in,
  input  wire logic [63:0]         b_in,
  input  wire cia_pkg::cmd_t       cmd,
  output cia_pkg::status_t         sts,
  output logic [63:0]              value,
  output logic                     raises
);

  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;

  logic [4:0]  op;
  logic [63:0] a, b;
  logic [63:0] res;
  logic        err;
  logic        div_raise;

  // divider
  logic [63:0] quo, rem, dvs;
  logic [5:0]  cnt;

  // power
  logic [63:0] acc, fac, n;
  logic [63:0] my;
  logic        mneg;
  logic [63:0] ll, lh, hl, hh;
  logic        mzero;

  // convert
  logic [63:0] ka;

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] to_f64(input logic [63:0] x);
    logic [63:0] m, keep, rmd, half, sh_m;
    logic [5:0]  p;
    logic [5:0]  sh;
    logic [10:0] e;
    logic        up;
    m = mag(x);
    p = 6'd0;
    for (int i = 0; i < 64; i++) if (m[i]) p = 6'(i);
    e = 11'(p) + 11'd1023;
    if (p <= 6'd52) begin
      keep = m << (6'd52 - p);
    end else begin
      sh = p - 6'd52;
      sh_m = (64'd1 << sh) - 64'd1;
      rmd = m & sh_m;
      half = 64'd1 << (sh - 6'd1);
      keep = m >> sh;
      up = (rmd > half) || ((rmd == half) && keep[0]);
      if (up) begin
        keep = keep + 64'd1;
        if (keep[53]) begin
          keep = keep >> 1;
          e = e + 11'd1;
        end
      end
    end
    if (m == 64'd0) return 64'd0;
    return {x[63], e, keep[51:0]};
  endfunction

  function automatic logic [63:0] okey(input logic [63:0] x);
    return x[63] ? ~x : (x | SignBit);
  endfunction

  // fast ops
  logic [63:0] f_v;
  logic        f_err, f_fast;
  logic [64:0] dsub;
  logic [63:0] rem_sh;
  logic [63:0] mid, hi, lo, mres;
  logic        mok;

  always_comb begin
    logic [63:0] t;
    f_v = '0;
    f_err = 1'b0;
    f_fast = 1'b1;
    t = '0;
    unique case (op) inside
      cia_pkg::OP_ADD: begin
        t = a + b;
        f_v = t;
        f_err = ((a ^ t) & (b ^ t) & SignBit) != 0;
      end
      cia_pkg::OP_SUB: begin
        t = a - b;
        f_v = t;
        f_err = ((a ^ b) & (a ^ t) & SignBit) != 0;
      end
      cia_pkg::OP_MUL: f_fast = 1'b0;
      cia_pkg::OP_DIV, cia_pkg::OP_MOD: begin
        f_err = div_raise;
        f_fast = div_raise;
      end
      cia_pkg::OP_POW: begin
        f_err = b[63];
        f_fast = b[63];
      end
      cia_pkg::OP_NEG: begin
        f_err = (a == SignBit);
        f_v = 64'd0 - a;
      end
      cia_pkg::OP_BITNOT: f_v = ~a;
      cia_pkg::OP_AND: f_v = a & b;
      cia_pkg::OP_OR: f_v = a | b;
      cia_pkg::OP_XOR: f_v = a ^ b;
      cia_pkg::OP_SHL, cia_pkg::OP_SHR, cia_pkg::OP_USHR: begin
        f_err = (b > 64'd63);
        if (op == cia_pkg::OP_SHL) f_v = a << b[5:0];
        else if (op == cia_pkg::OP_SHR) f_v = $unsigned($signed(a) >>> b[5:0]);
        else f_v = a >> b[5:0];
      end
      cia_pkg::OP_NOT: f_v = {63'd0, a == 64'd0};
      cia_pkg::OP_LAND: f_v = {63'd0, (a != 64'd0) && (b != 64'd0)};
      cia_pkg::OP_LOR: f_v = {63'd0, (a != 64'd0) || (b != 64'd0)};
      cia_pkg::OP_WIDEN: f_fast = 1'b0;
      cia_pkg::OP_EQ: f_v = {63'd0, a == b};
      cia_pkg::OP_NE: f_v = {63'd0, a != b};
      cia_pkg::OP_LT, cia_pkg::OP_LE, cia_pkg::OP_GT, cia_pkg::OP_GE: f_fast = 1'b0;
      default: f_err = 1'b1;
    endcase
  end

  assign div_raise = (b == 64'd0) ||
                     ((op == cia_pkg::OP_DIV) && (a == SignBit) && (b == '1));

  // multiply check, products registered in the preceding cycle
  always_comb begin
    mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    hi = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
    lo = {mid[31:0], ll[31:0]};
    mok = mzero || ((hi == 64'd0) && (mneg ? (lo <= SignBit) : (lo < SignBit)));
    mres = mzero ? 64'd0 : (mneg ? (64'd0 - lo) : lo);
  end

  assign rem_sh = {rem[62:0], quo[63]};
  assign dsub = {1'b0, rem_sh} - {1'b0, dvs};

  always_comb begin
    sts.fast = f_fast;
    sts.is_div = (op == cia_pkg::OP_DIV) || (op == cia_pkg::OP_MOD);
    sts.is_pow = (op == cia_pkg::OP_POW) || (op == cia_pkg::OP_MUL);
    sts.is_cvt = (op == cia_pkg::OP_WIDEN);
    sts.is_cmp = !sts.is_cvt;
    sts.div_last = (cnt == 6'd63);
    sts.pow_more = (n[63:1] != 63'd0);
    sts.pow_err = !mok;
  end

  logic [63:0] pmx, pmy, pax, pay;
  always_comb begin
    pmx = cmd.pow_sq ? fac : acc;
    pmy = fac;
    pax = mag(pmx);
    pay = mag(pmy);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_in;
      a <= a_in;
      b <= b_in;
    end
    if (cmd.decode) begin
      res <= f_v;
      err <= f_err;
      quo <= mag(a);
      rem <= '0;
      dvs <= mag(b);
      cnt <= '0;
      if (op == cia_pkg::OP_MUL) begin
        acc <= a;
        fac <= b;
        n <= 64'd1;
      end else begin
        acc <= 64'd1;
        fac <= a;
        n <= b;
      end
    end
    if (cmd.div_step) begin
      cnt <= cnt + 6'd1;
      if (!dsub[64]) begin
        rem <= dsub[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[62:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      err <= 1'b0;
      if (op == cia_pkg::OP_DIV) res <= ((a ^ b) & SignBit) != 0 ? 64'd0 - quo : quo;
      else res <= a[63] ? 64'd0 - rem : rem;
    end
    if (cmd.pow_mul || cmd.pow_sq) begin
      // even exponent bit: no multiply, force a clean check
      mneg <= pmx[63] ^ pmy[63];
      mzero <= (cmd.pow_mul && !n[0]) || (pmx == 64'd0) || (pmy == 64'd0);
      ll <= {32'd0, pax[31:0]} * {32'd0, pay[31:0]};
      lh <= {32'd0, pax[31:0]} * {32'd0, pay[63:32]};
      hl <= {32'd0, pax[63:32]} * {32'd0, pay[31:0]};
      hh <= {32'd0, pax[63:32]} * {32'd0, pay[63:32]};
    end
    if (cmd.pow_mul_chk) begin
      if (n[0]) acc <= mres;
      else acc <= acc;
      n <= n >> 1;
      if (n[0] && !mok) begin
        err <= 1'b1;
        res <= '0;
      end else begin
        err <= 1'b0;
        res <= n[0] ? mres : acc;
      end
    end
    if (cmd.pow_sq_chk) begin
      fac <= mres;
      if (!mok) begin
        err <= 1'b1;
        res <= '0;
      end
    end
    if (cmd.cvt_a) ka <= to_f64(a);
    if (cmd.cvt_b) begin
      if (op == cia_pkg::OP_WIDEN) begin
        res <= ka;
        err <= 1'b0;
      end else begin
        ka <= okey(ka);
        my <= okey(to_f64(b));
      end
    end
    if (cmd.cmp) begin
      err <= 1'b0;
      case (op)
        cia_pkg::OP_LT: res <= {63'd0, ka < my};
        cia_pkg::OP_LE: res <= {63'd0, ka <= my};
        cia_pkg::OP_GT: res <= {63'd0, ka > my};
        default: res <= {63'd0, ka >= my};
      endcase
    end
  end

  assign value = err ? 64'd0 : res;
  assign raises = err;

endmodule
`default_nettype wire

[src/checked_int64_alu.sv]
`default_nettype none
// Checked 64-bit integer ALU, one word at a time.
// Logic, add/sub, neg, shifts, eq/ne and early raises finish at decode; mul
// multiplies and checks, widen converts, ordered compares convert both
// operands and compare. div/mod: one quotient bit per cycle (restoring
// divider), then a sign fix. pow: square-and-multiply; input ready again the
// cycle after the result is taken. Sync active-high reset to idle.
module checked_int64_alu (
  input wire logic clk,
  input wire logic rst,
  cia_in_if.sink   in_ch,
  cia_out_if.source out_ch
);

  cia_pkg::cmd_t    cmd;
  cia_pkg::status_t sts;
  logic [63:0]      v;
  logic             r;

  cia_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  cia_dp u_dp (
    .clk(clk), .op_in(in_ch.op), .a_in(in_ch.operand_a), .b_in(in_ch.operand_b),
    .cmd(cmd), .sts(sts), .value(v), .raises(r)
  );

  assign out_ch.value = v;
  assign out_ch.raises = r;

endmodule
`default_nettype wire
